// ===== src/hbq_pkg.sv =====
// Package for the binary max-heap queue: word types, field widths and code constants.
package hbq_pkg;

    localparam int KEY_W   = 32;
    localparam int SLOT_W  = 7;
    localparam int STORE_D = 128;

    localparam logic [1:0] FN_INSERT   = 2'd0;
    localparam logic [1:0] FN_EXTRACT  = 2'd1;
    localparam logic [1:0] FN_INCREASE = 2'd2;
    localparam logic [1:0] FN_DELETE   = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_EMPTY   = 3'd2;
    localparam logic [2:0] ST_BADPOS  = 3'd3;
    localparam logic [2:0] ST_SMALLER = 3'd4;

    typedef struct packed {
        logic [1:0]              func;
        logic signed [KEY_W-1:0] key;
        logic [SLOT_W-1:0]       position;
    } t_in_word;

    typedef struct packed {
        logic [2:0]              status;
        logic signed [KEY_W-1:0] extracted;
        logic signed [KEY_W-1:0] top_key;
        logic [SLOT_W-1:0]       count;
    } t_out_word;

endpackage

// ===== src/hbq_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read.
module hbq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/binary_max_heap_queue.sv =====
// Top level of the binary max-heap priority queue of signed 32-bit keys.
// The queue keeps up to min(CAPACITY, 127) signed keys as a max-heap in a
// single 128-word RAM (slot 1 is the root, the children of slot p are 2p and
// 2p+1). Each input word asks for an insert, an extract of the maximum, a
// key increase at a slot or a delete at a slot, and yields exactly one output
// word carrying the status, the extracted maximum (zero unless an extract
// succeeded), the root key afterwards (zero on an empty heap) and the count.
// Requests are handled one at a time: o_in_stall is high from acceptance
// until the result has been loaded into the output register, which then
// waits for the consumer independently. A full heap, an empty heap or a bad
// position goes from the accepting state straight to the finishing state,
// and a key that is too small passes through the compare state on the way.
// In a sift-up each tree level climbed takes a RAM read of the parent, then
// a compare and write-back; in a sift-down each level descended takes reads
// of the left and right child through the single read port, then the
// compare and write-back. The heap has seven levels, and the RAM's one read
// port sets this split into steps. The moving key is held in a register and
// only written once its final slot is known, so no slot is ever read in the
// same cycle as it is written. Storage needs no clearing after reset, since
// only slots from 1 up to the count are ever read.
module binary_max_heap_queue
    import hbq_pkg::*;
#(
    parameter int CAPACITY = 127
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    // The count and the slot numbers are seven bits wide, so larger
    // capacities behave as 127.
    localparam int         LIMIT_I    = (CAPACITY < 127) ? CAPACITY : 127;
    localparam logic [6:0] SLOT_LIMIT = LIMIT_I[6:0];

    typedef enum logic [11:0] {
        S_IDLE    = 12'b0000_0000_0001,
        S_EX_R1   = 12'b0000_0000_0010,
        S_EX_RL   = 12'b0000_0000_0100,
        S_INC_CMP = 12'b0000_0000_1000,
        S_DEL_R1  = 12'b0000_0001_0000,
        S_DEL_R2  = 12'b0000_0010_0000,
        S_UP_RD   = 12'b0000_0100_0000,
        S_UP_CMP  = 12'b0000_1000_0000,
        S_DN_RDL  = 12'b0001_0000_0000,
        S_DN_RDR  = 12'b0010_0000_0000,
        S_DN_CMP  = 12'b0100_0000_0000,
        S_DONE    = 12'b1000_0000_0000
    } t_state;

    t_state                    r_state, n_state;
    logic [SLOT_W-1:0]         r_cnt, n_cnt;
    logic [SLOT_W-1:0]         r_slot, n_slot;
    logic [SLOT_W-1:0]         r_pos, n_pos;
    logic signed [KEY_W-1:0]   r_key, n_key;
    logic signed [KEY_W-1:0]   r_val, n_val;
    logic signed [KEY_W-1:0]   r_left, n_left;
    logic signed [KEY_W-1:0]   r_ext, n_ext;
    logic signed [KEY_W-1:0]   r_top;
    logic [2:0]                r_status, n_status;
    logic                      r_out_valid;
    t_out_word                 r_out_word;

    logic                      ram_we, ram_re;
    logic [SLOT_W-1:0]         ram_waddr, ram_raddr;
    logic [KEY_W-1:0]          ram_wdata, ram_rdata;
    logic signed [KEY_W-1:0]   rd_key;

    logic                      in_acc;
    logic                      out_free;
    logic [SLOT_W:0]           left_ix, right_ix;
    logic                      left_ok, right_ok;
    logic                      take_left, take_right;
    logic signed [KEY_W-1:0]   big_lv;

    hbq_ram #(
        .WIDTH (KEY_W),
        .DEPTH (STORE_D)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_key     = $signed(ram_rdata);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // Children of the current slot; eight bits wide so slot 127 does not wrap.
    assign left_ix  = {r_slot, 1'b0};
    assign right_ix = {r_slot, 1'b1};
    assign left_ok  = (left_ix <= {1'b0, r_cnt});
    assign right_ok = (right_ix <= {1'b0, r_cnt});

    // Sift-down choice: ties never move an entry, and the right child wins
    // only when it is strictly larger than both the moving key and the left.
    assign take_left  = r_left > r_val;
    assign big_lv     = take_left ? r_left : r_val;
    assign take_right = right_ok && (rd_key > big_lv);

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_slot    = r_slot;
        n_pos     = r_pos;
        n_key     = r_key;
        n_val     = r_val;
        n_left    = r_left;
        n_ext     = r_ext;
        n_status  = r_status;
        ram_we    = 1'b0;
        ram_waddr = r_slot;
        ram_wdata = r_val;
        ram_re    = 1'b0;
        ram_raddr = r_slot;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_key    = i_in_word.key;
                    n_pos    = i_in_word.position;
                    n_ext    = '0;
                    n_status = ST_OK;
                    case (i_in_word.func)
                        FN_INSERT: begin
                            if (r_cnt >= SLOT_LIMIT) begin
                                n_status = ST_FULL;
                                n_state  = S_DONE;
                            end else begin
                                n_cnt   = r_cnt + 1'b1;
                                n_slot  = r_cnt + 1'b1;
                                n_val   = i_in_word.key;
                                n_state = S_UP_RD;
                            end
                        end
                        FN_EXTRACT: begin
                            if (r_cnt == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_DONE;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = SLOT_W'(1);
                                n_state   = S_EX_R1;
                            end
                        end
                        FN_INCREASE: begin
                            if (i_in_word.position == '0 || i_in_word.position > r_cnt) begin
                                n_status = ST_BADPOS;
                                n_state  = S_DONE;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = i_in_word.position;
                                n_state   = S_INC_CMP;
                            end
                        end
                        default: begin
                            if (i_in_word.position == '0 || i_in_word.position > r_cnt) begin
                                n_status = ST_BADPOS;
                                n_state  = S_DONE;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = r_cnt;
                                n_state   = S_DEL_R1;
                            end
                        end
                    endcase
                end
            end

            S_EX_R1: begin
                n_ext     = rd_key;
                ram_re    = 1'b1;
                ram_raddr = r_cnt;
                n_state   = S_EX_RL;
            end

            S_EX_RL: begin
                n_val   = rd_key;
                n_cnt   = r_cnt - 1'b1;
                n_slot  = SLOT_W'(1);
                n_state = S_DN_RDL;
            end

            S_INC_CMP: begin
                if (r_key < rd_key) begin
                    n_status = ST_SMALLER;
                    n_state  = S_DONE;
                end else begin
                    n_val   = r_key;
                    n_slot  = r_pos;
                    n_state = S_UP_RD;
                end
            end

            S_DEL_R1: begin
                n_val     = rd_key;
                ram_re    = 1'b1;
                ram_raddr = r_pos;
                n_state   = S_DEL_R2;
            end

            S_DEL_R2: begin
                n_cnt  = r_cnt - 1'b1;
                n_slot = r_pos;
                if (r_pos <= r_cnt - 1'b1) begin
                    n_state = (r_val > rd_key) ? S_UP_RD : S_DN_RDL;
                end else begin
                    n_state = S_DONE;
                end
            end

            S_UP_RD: begin
                if (r_slot == SLOT_W'(1)) begin
                    ram_we  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = r_slot >> 1;
                    n_state   = S_UP_CMP;
                end
            end

            S_UP_CMP: begin
                ram_we = 1'b1;
                if (rd_key < r_val) begin
                    ram_wdata = rd_key;
                    n_slot    = r_slot >> 1;
                    n_state   = S_UP_RD;
                end else begin
                    n_state = S_DONE;
                end
            end

            S_DN_RDL: begin
                if (left_ok) begin
                    ram_re    = 1'b1;
                    ram_raddr = left_ix[SLOT_W-1:0];
                    n_state   = S_DN_RDR;
                end else begin
                    ram_we  = 1'b1;
                    n_state = S_DONE;
                end
            end

            S_DN_RDR: begin
                n_left = rd_key;
                if (right_ok) begin
                    ram_re    = 1'b1;
                    ram_raddr = right_ix[SLOT_W-1:0];
                end
                n_state = S_DN_CMP;
            end

            S_DN_CMP: begin
                ram_we = 1'b1;
                if (take_right) begin
                    ram_wdata = rd_key;
                    n_slot    = right_ix[SLOT_W-1:0];
                    n_state   = S_DN_RDL;
                end else if (take_left) begin
                    ram_wdata = r_left;
                    n_slot    = left_ix[SLOT_W-1:0];
                    n_state   = S_DN_RDL;
                end else begin
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers and the output word. The root key is shadowed
    // from every write to slot 1, so the result needs no extra read.
    always_ff @(posedge i_clk) begin
        r_slot   <= n_slot;
        r_pos    <= n_pos;
        r_key    <= n_key;
        r_val    <= n_val;
        r_left   <= n_left;
        r_ext    <= n_ext;
        r_status <= n_status;
        if (ram_we && ram_waddr == SLOT_W'(1)) begin
            r_top <= $signed(ram_wdata);
        end
        if (r_state == S_DONE && out_free) begin
            r_out_word.status    <= r_status;
            r_out_word.extracted <= r_ext;
            r_out_word.top_key   <= (r_cnt != '0) ? r_top : '0;
            r_out_word.count     <= r_cnt;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    a_cnt_limit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= SLOT_LIMIT)
        else $error("entry count above the slot limit");

    a_out_from_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("result word appeared without a finished request");

    a_busy_after_acc : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state != S_IDLE)
        else $error("block idle straight after accepting a word");

    a_no_write_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_DONE) |-> !ram_we)
        else $error("store written outside an operation");

    a_sink_read_live : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DN_RDL || r_state == S_DN_RDR) && ram_re) |-> ram_raddr <= r_cnt)
        else $error("sift-down read beyond the live entries");

endmodule

// ===== test/tb_binary_max_heap_queue.sv =====
// Self-checking testbench for the binary max-heap priority queue.
`timescale 1ns / 100ps

module tb_binary_max_heap_queue;
    import hbq_pkg::*;

    // Largest number of live entries with the default CAPACITY.
    localparam int SLOT_LIMIT   = 127;
    // Cycles that the receiver refuses every word during a hold-off.
    localparam int HOLD_CYCLES  = 250;
    // Results between the starts of two hold-offs.
    localparam int HOLD_SPACING = 150;
    // Quiet cycles after the last result, above the longest operation.
    localparam int DRAIN_CYCLES = 40;

    localparam logic [KEY_W-1:0] KEY_MOST_NEG = 32'h8000_0000;
    localparam logic [KEY_W-1:0] KEY_MAX      = 32'h7fff_ffff;
    localparam logic [KEY_W-1:0] KEY_MIN_SYM  = 32'h8000_0001;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_word  i_in_word   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_word o_out_word;

    // Request words waiting to be offered, and results still owed by the block.
    t_in_word  pending_requests [$];
    t_out_word owed_results [$];

    int total_requests = 0;
    int requests_taken = 0;
    int results_seen   = 0;
    int mismatch_count = 0;
    int hold_left      = 0;
    int next_hold_at   = HOLD_SPACING;

    // Our own mirror of the heap, advanced once per accepted request word.
    logic signed [KEY_W-1:0] heap_mirror [STORE_D];
    int mirror_count = 0;

    binary_max_heap_queue u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Heap mirror: the same sift rules as the block, on plain arrays.
    // ------------------------------------------------------------------
    function automatic void mirror_swap(int a, int b);
        logic signed [KEY_W-1:0] held;
        held           = heap_mirror[a];
        heap_mirror[a] = heap_mirror[b];
        heap_mirror[b] = held;
    endfunction

    // Climb towards the root while the parent is strictly smaller; ties stay put.
    function automatic void mirror_raise(int slot);
        int up;
        bit climbing;
        climbing = 1'b1;
        while (climbing && slot > 1) begin
            up = slot / 2;
            if (heap_mirror[up] < heap_mirror[slot]) begin
                mirror_swap(up, slot);
                slot = up;
            end else begin
                climbing = 1'b0;
            end
        end
    endfunction

    // Descend while a live child is strictly larger; the left child wins a tie.
    function automatic void mirror_sink(int slot);
        int lchild;
        int rchild;
        int best;
        bit sinking;
        sinking = 1'b1;
        while (sinking) begin
            lchild = slot * 2;
            rchild = lchild + 1;
            best   = slot;
            if (lchild <= mirror_count && heap_mirror[lchild] > heap_mirror[best])
                best = lchild;
            if (rchild <= mirror_count && heap_mirror[rchild] > heap_mirror[best])
                best = rchild;
            if (best == slot) begin
                sinking = 1'b0;
            end else begin
                mirror_swap(slot, best);
                slot = best;
            end
        end
    endfunction

    // Applies one request word to the mirror and returns the result word it owes.
    function automatic t_out_word heap_outcome(t_in_word req);
        t_out_word outcome;
        logic signed [KEY_W-1:0] new_key;
        logic signed [KEY_W-1:0] moved;
        logic signed [KEY_W-1:0] displaced;
        int slot;
        outcome        = '0;
        outcome.status = ST_OK;
        new_key        = req.key;
        slot           = req.position;
        case (req.func)
            FN_INSERT: begin
                if (mirror_count >= SLOT_LIMIT) begin
                    outcome.status = ST_FULL;
                end else begin
                    mirror_count++;
                    heap_mirror[mirror_count] = new_key;
                    mirror_raise(mirror_count);
                end
            end
            FN_EXTRACT: begin
                if (mirror_count == 0) begin
                    outcome.status = ST_EMPTY;
                end else begin
                    outcome.extracted = heap_mirror[1];
                    heap_mirror[1]    = heap_mirror[mirror_count];
                    mirror_count--;
                    mirror_sink(1);
                end
            end
            FN_INCREASE: begin
                if (slot == 0 || slot > mirror_count) begin
                    outcome.status = ST_BADPOS;
                end else if (new_key < heap_mirror[slot]) begin
                    outcome.status = ST_SMALLER;
                end else begin
                    heap_mirror[slot] = new_key;
                    mirror_raise(slot);
                end
            end
            FN_DELETE: begin
                if (slot == 0 || slot > mirror_count) begin
                    outcome.status = ST_BADPOS;
                end else begin
                    // The last entry fills the hole, then moves whichever way it must.
                    moved     = heap_mirror[mirror_count];
                    displaced = heap_mirror[slot];
                    mirror_count--;
                    heap_mirror[slot] = moved;
                    if (slot <= mirror_count) begin
                        if (moved > displaced)
                            mirror_raise(slot);
                        else
                            mirror_sink(slot);
                    end
                end
            end
            default: ;
        endcase
        outcome.top_key = (mirror_count != 0) ? heap_mirror[1] : '0;
        outcome.count   = mirror_count[SLOT_W-1:0];
        return outcome;
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers the pending request words, with a random gap before
    // each one. Now and then it switches into an eager stretch in which the
    // gaps vanish, so that back-to-back words are seen as well.
    // A word that is stalled is held unchanged with valid high.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : driver_proc
        int  send_gap;
        bit  send_eager;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap   = $urandom_range(0, 4);
            send_eager = 1'b0;
        end else begin
            // The mirror moves on at the very edge at which the block takes the word.
            if (i_in_valid && !o_in_stall) begin
                owed_results.push_back(heap_outcome(i_in_word));
                requests_taken <= requests_taken + 1;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap == 0 && pending_requests.size() != 0) begin
                    i_in_word  <= pending_requests.pop_front();
                    i_in_valid <= 1'b1;
                    if ($urandom_range(0, 19) == 0)
                        send_eager = !send_eager;
                    send_gap = send_eager ? 0 : $urandom_range(0, 4);
                end else begin
                    i_in_valid <= 1'b0;
                    if (send_gap != 0)
                        send_gap--;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: takes result words, with a random stall after each one (or
    // not at all in an eager stretch), and compares every field with the
    // oldest result owed. A long hold-off from the pressure process below
    // forces the stall high as well.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor_proc
        t_out_word due;
        int  recv_wait;
        bit  recv_eager;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            recv_wait  = 0;
            recv_eager = 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (owed_results.size() == 0) begin
                    $display({"%0t: result word with nothing owed: ",
                              "status %0d extracted %0d top %0d count %0d"},
                             $time, o_out_word.status, o_out_word.extracted,
                             o_out_word.top_key, o_out_word.count);
                    mismatch_count++;
                end else begin
                    due = owed_results.pop_front();
                    if (o_out_word.status !== due.status ||
                        o_out_word.extracted !== due.extracted ||
                        o_out_word.top_key !== due.top_key ||
                        o_out_word.count !== due.count) begin
                        $display("%0t: expected status %0d extracted %0d top %0d count %0d",
                                 $time, due.status, due.extracted, due.top_key, due.count);
                        $display("%0t:   actual status %0d extracted %0d top %0d count %0d",
                                 $time, o_out_word.status, o_out_word.extracted,
                                 o_out_word.top_key, o_out_word.count);
                        mismatch_count++;
                    end
                end
                results_seen <= results_seen + 1;
                if ($urandom_range(0, 23) == 0)
                    recv_eager = !recv_eager;
                recv_wait = recv_eager ? 0 : $urandom_range(0, 4);
            end
            i_out_stall <= (hold_left != 0) || (recv_wait != 0);
            if (recv_wait != 0)
                recv_wait--;
        end
    end

    // ------------------------------------------------------------------
    // Pressure: every HOLD_SPACING results the receiver is held off for a
    // long stretch. The block then holds one result in its output register,
    // finishes the request behind it and stalls its input, while the driver
    // keeps a word on offer.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : hold_proc
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (results_seen >= next_hold_at) begin
            hold_left    <= HOLD_CYCLES;
            next_hold_at <= next_hold_at + HOLD_SPACING;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus. The count after a request depends only on the operation and
    // on whether the position lies in range, so the planner tracks it exactly
    // and can aim positions at live slots and steer the heap to full or empty.
    // ------------------------------------------------------------------
    int plan_count = 0;

    task automatic add_request(logic [1:0] func, logic [KEY_W-1:0] key, int position);
        t_in_word req;
        req.func     = func;
        req.key      = key;
        req.position = position[SLOT_W-1:0];
        pending_requests.push_back(req);
        case (func)
            FN_INSERT:  if (plan_count < SLOT_LIMIT) plan_count++;
            FN_EXTRACT: if (plan_count > 0) plan_count--;
            FN_DELETE:  if (position != 0 && position <= plan_count) plan_count--;
            default: ;
        endcase
    endtask

    // Keys lean on the extremes and on a narrow band around zero for ties.
    function automatic logic [KEY_W-1:0] random_key();
        case ($urandom_range(0, 9))
            0:       return KEY_MOST_NEG;
            1:       return KEY_MAX;
            2:       return KEY_MIN_SYM;
            3, 4, 5: return $urandom_range(0, 16) - 8;
            default: return $urandom();
        endcase
    endfunction

    // A new key for an increase: mostly large, so that most are accepted.
    function automatic logic [KEY_W-1:0] raised_key();
        case ($urandom_range(0, 3))
            0:       return $urandom();
            1:       return KEY_MAX;
            default: return 32'h4000_0000 | ($urandom() >> 2);
        endcase
    endfunction

    // Mostly a live slot; otherwise any position at all, which is often bad.
    function automatic int random_position();
        if (plan_count > 0 && $urandom_range(0, 99) < 85)
            return $urandom_range(1, plan_count);
        return $urandom_range(0, 127);
    endfunction

    task automatic add_mixed(int n, int insert_pct);
        int pick;
        repeat (n) begin
            if ($urandom_range(0, 99) < insert_pct) begin
                add_request(FN_INSERT, random_key(), $urandom_range(0, 127));
            end else begin
                pick = $urandom_range(0, 9);
                if (pick < 3)
                    add_request(FN_EXTRACT, $urandom(), $urandom_range(0, 127));
                else if (pick < 7)
                    add_request(FN_INCREASE, raised_key(), random_position());
                else
                    add_request(FN_DELETE, $urandom(), random_position());
            end
        end
    endtask

    initial begin
        // Directed opening: every error on an empty heap first.
        add_request(FN_EXTRACT, 32'd0, 0);
        add_request(FN_INCREASE, 32'd5, 1);
        add_request(FN_DELETE, 32'd0, 0);
        add_request(FN_DELETE, 32'd0, 1);
        // Extreme keys, the most negative pattern among them, and a repeated key.
        add_request(FN_INSERT, KEY_MOST_NEG, 0);
        add_request(FN_INSERT, KEY_MAX, 127);
        add_request(FN_INSERT, KEY_MIN_SYM, 0);
        add_request(FN_INSERT, 32'd99, 0);
        add_request(FN_INSERT, 32'd0, 0);
        add_request(FN_INSERT, 32'd99, 0);
        // Bad positions at both ends, a smaller key, then a key that ties the root.
        add_request(FN_INCREASE, 32'd0, 0);
        add_request(FN_INCREASE, KEY_MAX, 127);
        add_request(FN_INCREASE, KEY_MOST_NEG, 1);
        add_request(FN_INCREASE, KEY_MAX, 6);
        // Deletes of the last slot, an inner slot and the root, then drain to empty.
        add_request(FN_DELETE, 32'd0, 6);
        add_request(FN_DELETE, 32'd0, 2);
        add_request(FN_DELETE, 32'd0, 1);
        repeat (3) add_request(FN_EXTRACT, 32'd0, 0);
        add_request(FN_EXTRACT, KEY_MAX, 127);

        // Random part: a mixed stretch, then fill to the limit and push on it,
        // then drain to empty by extracts and deletes, then a last mixed stretch.
        add_mixed(240, 40);
        while (plan_count < SLOT_LIMIT)
            add_request(FN_INSERT, random_key(), $urandom_range(0, 127));
        repeat (4) add_request(FN_INSERT, random_key(), $urandom_range(0, 127));
        add_request(FN_INCREASE, raised_key(), SLOT_LIMIT);
        add_request(FN_DELETE, 32'd0, SLOT_LIMIT);
        add_mixed(20, 60);
        while (plan_count > 0) begin
            if ($urandom_range(0, 9) < 6)
                add_request(FN_EXTRACT, $urandom(), $urandom_range(0, 127));
            else
                add_request(FN_DELETE, $urandom(), $urandom_range(1, plan_count));
        end
        add_request(FN_EXTRACT, 32'd0, 0);
        add_request(FN_DELETE, 32'd0, 1);
        add_mixed(80, 50);
        total_requests = pending_requests.size();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sampled on the falling edge, once every clocked process has settled.
        do @(negedge i_clk);
        while (requests_taken != total_requests || owed_results.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog: a time limit far beyond the slowest correct run.
    initial begin
        #1_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
src/hbq_pkg.sv
src/hbq_ram.sv
src/binary_max_heap_queue.sv
test/tb_binary_max_heap_queue.sv
